/* rtl/bcpr_pkg.sv */
// Shared widths, constants and codes for the bit counter pitch ratio core.
`timescale 1ns / 1ps
`default_nettype none

package bcpr_pkg;

	// Counter and timestamp arithmetic widths
	localparam int COUNT_WIDTH = 32;
	localparam int TIME_WIDTH  = 64;

	// Port field widths
	localparam int COUNT_IN_W = 32;
	localparam int TIME_IN_W  = 63;
	localparam int BPF_W      = 11;
	localparam int NOM_W      = 19;
	localparam int PITCH_W    = 21;
	localparam int CFG_W      = 21;
	localparam int CFG_IDX_W  = 2;

	// Scale factors
	localparam int NS_W  = 30;
	localparam int PPM_W = 20;
	localparam logic [NS_W-1:0]  NS_PER_S  = NS_W'(1000000000);
	localparam logic [PPM_W-1:0] PPM_UNITY = PPM_W'(1000000);

	// Register reset values
	localparam logic [BPF_W-1:0]   BPF_RST  = BPF_W'(256);
	localparam logic [NOM_W-1:0]   NOM_RST  = NOM_W'(48000);
	localparam logic [PITCH_W-1:0] PMIN_RST = PITCH_W'(750000);
	localparam logic [PITCH_W-1:0] PMAX_RST = PITCH_W'(1005000);

	// Datapath widths
	localparam int NUM_W = COUNT_WIDTH + NS_W;   // dbits * 1e9
	localparam int DEN_W = TIME_WIDTH + BPF_W;   // dns * bits_per_frame
	localparam int SCL_W = NUM_W + PPM_W;        // rate * 1e6
	localparam int ACC_W = (SCL_W > DEN_W) ? SCL_W : DEN_W;
	localparam int ADD_W = (ACC_W > DEN_W + 1) ? ACC_W : DEN_W + 1;
	localparam int OP_W  = (TIME_WIDTH > NUM_W) ? TIME_WIDTH : NUM_W;
	localparam int MUL_W = NS_W;
	localparam int STEP_W = $clog2(SCL_W + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BPF  = 2'd0,
		CFG_NOM  = 2'd1,
		CFG_PMIN = 2'd2,
		CFG_PMAX = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEN,
		ST_NUM,
		ST_DIV1,
		ST_SCL,
		ST_DIV2,
		ST_CLAMP
	} state_t;

endpackage

`default_nettype wire

/* rtl/bit_counter_pitch_ratio_core.sv */
// Pitch ratio from successive bit counter snapshots, on one shared add/subtract unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | request   | in_valid / in_ready  | bit_count[31:0], time_ns[62:0]
//  out     | result    | out_valid / out_ready| pitch_ppm[20:0]
//  cfg     | write     | cfg_we               | cfg_index[1:0], cfg_data[20:0]
//
// A request that yields a pitch occupies the core through an accept step, the
// den, num, divide, scale and divide serial phases, and a clamp step, all on the single
// wide adder doing shift-add multiplies and restoring divides one bit a cycle.
// A request that yields nothing (first after reset, zero difference, zero
// bits_per_frame or nominal_rate) is absorbed in its accept cycle.
// in_ready is high only while idle; a finished pitch waits in the output
// register, and the core holds in the clamp step if the previous one is unread.
// Reset restores the register defaults and forgets the stored snapshot.
`timescale 1ns / 1ps
`default_nettype none

module bit_counter_pitch_ratio_core
	import bcpr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// snapshot requests
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [COUNT_IN_W-1:0] bit_count,
	input  wire logic [TIME_IN_W-1:0]  time_ns,
	// pitch results
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PITCH_W-1:0]        pitch_ppm,
	// register writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic [BPF_W-1:0]   bpf_q;
	logic [NOM_W-1:0]   nom_q;
	logic [PITCH_W-1:0] pmin_q;
	logic [PITCH_W-1:0] pmax_q;

	// Stored snapshot
	logic [COUNT_WIDTH-1:0] prev_count_q;
	logic [TIME_WIDTH-1:0]  prev_time_q;
	logic                   primed_q;

	// Sequencer
	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q;
	logic              last;

	// Datapath
	logic [ACC_W-1:0]       acc_q;    // product, then numerator/quotient
	logic [DEN_W-1:0]       rem_q;    // division remainder
	logic [DEN_W-1:0]       div_q;    // divisor
	logic [OP_W-1:0]        op_q;     // multiplicand
	logic [MUL_W-1:0]       mlt_q;    // multiplier, MSB first
	logic [COUNT_WIDTH-1:0] dbits_q;

	logic                   out_valid_q;
	logic [PITCH_W-1:0]     pitch_q;

	// Snapshot differences and the go/skip decision
	logic [COUNT_WIDTH-1:0] dbits;
	logic [TIME_WIDTH-1:0]  dns;
	logic                   accept;
	logic                   run;

	// Shared add/subtract unit
	logic [ADD_W-1:0] add_a, add_b;
	logic             add_sub;
	logic [ADD_W:0]   sum;
	logic             carry;
	logic             div_st;
	logic [ACC_W-1:0] acc_div;
	logic [DEN_W-1:0] rem_div;

	// Clamp
	logic             gt_max;
	logic [PITCH_W-1:0] p_raw, p_lo, p_clamp;
	logic             out_free;

	assign dbits  = COUNT_WIDTH'(bit_count) - prev_count_q;
	assign dns    = TIME_WIDTH'(time_ns) - prev_time_q;
	assign accept = in_valid && in_ready;
	assign run    = primed_q && (dbits != '0) && (dns != '0)
		&& (bpf_q != '0) && (nom_q != '0);
	assign last   = (cnt_q == STEP_W'(1));
	assign div_st = (state_q == ST_DIV1) || (state_q == ST_DIV2);

	// Multiply step: acc = 2*acc + bit*op.  Divide step: trial subtract.
	always_comb begin
		if (div_st) begin
			add_a   = ADD_W'({rem_q, acc_q[ACC_W-1]});
			add_b   = ADD_W'(div_q);
			add_sub = 1'b1;
		end else begin
			add_a   = ADD_W'(acc_q << 1);
			add_b   = mlt_q[MUL_W-1] ? ADD_W'(op_q) : '0;
			add_sub = 1'b0;
		end
	end

	assign sum     = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (ADD_W+1)'(add_sub);
	assign carry   = sum[ADD_W];   // no borrow on subtract
	assign acc_div = {acc_q[ACC_W-2:0], carry};
	assign rem_div = carry ? sum[DEN_W-1:0] : {rem_q[DEN_W-2:0], acc_q[ACC_W-1]};

	// Clamp: above max gives max, then raise to min, then cap at max
	assign gt_max  = acc_q > ACC_W'(pmax_q);
	assign p_raw   = gt_max ? pmax_q : acc_q[PITCH_W-1:0];
	assign p_lo    = (p_raw < pmin_q) ? pmin_q : p_raw;
	assign p_clamp = (p_lo > pmax_q) ? pmax_q : p_lo;
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && run)
					state_d = ST_DEN;
			end
			ST_DEN:   if (last) state_d = ST_NUM;
			ST_NUM:   if (last) state_d = ST_DIV1;
			ST_DIV1:  if (last) state_d = ST_SCL;
			ST_SCL:   if (last) state_d = ST_DIV2;
			ST_DIV2:  if (last) state_d = ST_CLAMP;
			ST_CLAMP: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpf_q        <= BPF_RST;
			nom_q        <= NOM_RST;
			pmin_q       <= PMIN_RST;
			pmax_q       <= PMAX_RST;
			prev_count_q <= '0;
			prev_time_q  <= '0;
			primed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_BPF:  bpf_q  <= cfg_data[BPF_W-1:0];
					CFG_NOM:  nom_q  <= cfg_data[NOM_W-1:0];
					CFG_PMIN: pmin_q <= cfg_data[PITCH_W-1:0];
					CFG_PMAX: pmax_q <= cfg_data[PITCH_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				prev_count_q <= COUNT_WIDTH'(bit_count);
				prev_time_q  <= TIME_WIDTH'(time_ns);
				primed_q     <= 1'b1;
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_CLAMP && out_free)
				out_valid_q <= 1'b1;

			// step counter: loaded on entry to each serial phase
			unique case (state_q)
				ST_IDLE:  if (accept && run) cnt_q <= STEP_W'(BPF_W);
				ST_DEN:   cnt_q <= last ? STEP_W'(NS_W)  : cnt_q - STEP_W'(1);
				ST_NUM:   cnt_q <= last ? STEP_W'(NUM_W) : cnt_q - STEP_W'(1);
				ST_DIV1:  cnt_q <= last ? STEP_W'(PPM_W) : cnt_q - STEP_W'(1);
				ST_SCL:   cnt_q <= last ? STEP_W'(SCL_W) : cnt_q - STEP_W'(1);
				ST_DIV2:  cnt_q <= cnt_q - STEP_W'(1);
				ST_CLAMP: cnt_q <= '0;
				default:  cnt_q <= '0;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && run) begin
					// den = dns * bits_per_frame
					acc_q   <= '0;
					op_q    <= OP_W'(dns);
					dbits_q <= dbits;
					mlt_q   <= MUL_W'(bpf_q) << (MUL_W - BPF_W);
				end
			end
			ST_DEN: begin
				mlt_q <= mlt_q << 1;
				acc_q <= sum[ACC_W-1:0];
				if (last) begin
					// num = dbits * 1e9
					div_q <= sum[DEN_W-1:0];
					acc_q <= '0;
					op_q  <= OP_W'(dbits_q);
					mlt_q <= MUL_W'(NS_PER_S);
				end
			end
			ST_NUM: begin
				mlt_q <= mlt_q << 1;
				acc_q <= sum[ACC_W-1:0];
				if (last) begin
					// numerator MSB aligned to the top of acc
					acc_q <= sum[ACC_W-1:0] << (ACC_W - NUM_W);
					rem_q <= '0;
				end
			end
			ST_DIV1: begin
				acc_q <= acc_div;
				rem_q <= rem_div;
				if (last) begin
					// scaled = rate * 1e6
					op_q  <= OP_W'(acc_div);
					acc_q <= '0;
					mlt_q <= MUL_W'(PPM_UNITY) << (MUL_W - PPM_W);
				end
			end
			ST_SCL: begin
				mlt_q <= mlt_q << 1;
				acc_q <= sum[ACC_W-1:0];
				if (last) begin
					acc_q <= sum[ACC_W-1:0] << (ACC_W - SCL_W);
					div_q <= DEN_W'(nom_q);
					rem_q <= '0;
				end
			end
			ST_DIV2: begin
				acc_q <= acc_div;
				rem_q <= rem_div;
			end
			ST_CLAMP: begin
				if (out_free)
					pitch_q <= p_clamp;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign pitch_ppm = pitch_q;

	// Assertions
	a_skip_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !primed_q |=> state_q == ST_IDLE)
		else $error("unprimed request started a computation");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV1 |-> div_q != '0)
		else $error("frame rate divisor is zero");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV1 |-> rem_q < div_q)
		else $error("remainder not below divisor");

	a_steps_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE && state_q != ST_CLAMP |-> cnt_q != '0)
		else $error("serial phase running with no steps left");

	a_clamp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLAMP && out_valid_q && !out_ready |=> state_q == ST_CLAMP)
		else $error("pitch overwrote an unread result");

endmodule

`default_nettype wire

/* tb/tb_bit_counter_pitch_ratio_core.sv */
// Self-checking testbench for the bit counter pitch ratio core: directed and random snapshots.
`timescale 1ns / 1ps

module tb_bit_counter_pitch_ratio_core
	import bcpr_pkg::*;
();

	// Run limit. A pitch costs one full core computation, plus receiver stall and
	// sender gap bursts; ~1850 requests give the expected run length. Three times
	// that, rounded up, still ends a hung run quickly.
	localparam int unsigned CYCLE_LIMIT     = 1_500_000;
	localparam int          HOLD_OFF_CYCLES = 900;   // long receiver hold-off
	localparam int          IDLE_GUARD      = 250;   // > one full pitch computation
	localparam int          RANDOM_CHUNKS   = 12;
	localparam int          CHUNK_ITEMS     = 152;

	// Predicted result: produced flag and the clamped pitch
	typedef struct packed {
		logic               produced;
		logic [PITCH_W-1:0] pitch;
	} pitch_pred_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [COUNT_IN_W-1:0] bit_count = '0;
	logic [TIME_IN_W-1:0]  time_ns   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b1;
	logic [PITCH_W-1:0]    pitch_ppm;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;

	// Predictor copy of the registers and the stored snapshot
	logic [BPF_W-1:0]      r_bpf  = BPF_RST;
	logic [NOM_W-1:0]      r_nom  = NOM_RST;
	logic [PITCH_W-1:0]    r_pmin = PMIN_RST;
	logic [PITCH_W-1:0]    r_pmax = PMAX_RST;
	logic [COUNT_WIDTH-1:0] last_count    = '0;
	logic [TIME_WIDTH-1:0]  last_time     = '0;
	logic                   have_snapshot = 1'b0;

	logic [PITCH_W-1:0] pending_pitch[$];   // pitches owed by the core, oldest first
	logic [PITCH_W-1:0] owed;

	int unsigned cycle_count    = 0;
	int          mismatches     = 0;
	int          requests_sent  = 0;
	int          pitches_seen   = 0;
	int          settings_used  = 1;   // reset values count as the first
	int          tx_gap_odds    = 0;   // percent chance of an idle burst per request
	int          rx_stall_odds  = 0;   // percent chance of a stall burst per cycle
	logic        hold_off_req   = 1'b0;

	bit_counter_pitch_ratio_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.bit_count (bit_count),
		.time_ns   (time_ns),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pitch_ppm (pitch_ppm),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d pitches still owed", $time, pending_pitch.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Pitch from one pair of differences, at full width so nothing wraps.
	// A zero difference or a zero divisor register gives no pitch at all.
	function automatic pitch_pred_t predict_pitch(input logic [COUNT_WIDTH-1:0] dbits,
						      input logic [TIME_WIDTH-1:0] dns);
		logic [127:0] num, den, frame_rate, scaled, ratio;
		pitch_pred_t  res;
		res = '0;
		if (dbits == 0 || dns == 0 || r_bpf == 0 || r_nom == 0)
			return res;
		num        = 128'(dbits) * 128'(64'd1_000_000_000);
		den        = 128'(dns) * 128'(r_bpf);
		frame_rate = num / den;
		scaled     = frame_rate * 128'(64'd1_000_000);
		ratio      = scaled / 128'(r_nom);
		// raise to the floor, then lower to the ceiling: ceiling wins if they cross
		res.pitch = (ratio > 128'(r_pmax)) ? r_pmax : ratio[PITCH_W-1:0];
		if (res.pitch < r_pmin)
			res.pitch = r_pmin;
		if (res.pitch > r_pmax)
			res.pitch = r_pmax;
		res.produced = 1'b1;
		return res;
	endfunction

	// Offer one snapshot request, hold it until accepted, then predict.
	// in_valid is left high so a back-to-back request needs no second NBA.
	task automatic send_snapshot(input logic [COUNT_IN_W-1:0] cnt,
				     input logic [TIME_IN_W-1:0] ts);
		logic [TIME_WIDTH-1:0] now;
		pitch_pred_t           pred;
		if (tx_gap_odds != 0 && $urandom_range(0, 99) < tx_gap_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		bit_count <= cnt;
		time_ns   <= ts;
		do @(posedge clk); while (!in_ready);
		now = {1'b0, ts};
		if (have_snapshot) begin
			pred = predict_pitch(cnt - last_count, now - last_time);
			if (pred.produced)
				pending_pitch.push_back(pred.pitch);
		end
		last_count    = cnt;
		last_time     = now;
		have_snapshot = 1'b1;
		requests_sent++;
	endtask

	// Next snapshot relative to the stored one; both deltas wrap.
	task automatic send_step(input logic [COUNT_WIDTH-1:0] dc, input logic [TIME_WIDTH-1:0] dt);
		logic [TIME_WIDTH-1:0] nt;
		nt = last_time + dt;
		send_snapshot(last_count + dc, nt[TIME_IN_W-1:0]);
	endtask

	// Sender goes quiet until every owed pitch is back, then lets the core
	// finish anything that yields no pitch before registers may change.
	task automatic drain_and_idle();
		in_valid <= 1'b0;
		while (pending_pitch.size() != 0) @(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_BPF:  r_bpf  = val[BPF_W-1:0];
			CFG_NOM:  r_nom  = val[NOM_W-1:0];
			CFG_PMIN: r_pmin = val[PITCH_W-1:0];
			CFG_PMAX: r_pmax = val[PITCH_W-1:0];
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_W-1:0] bpf, input logic [CFG_W-1:0] nom,
				     input logic [CFG_W-1:0] pmin, input logic [CFG_W-1:0] pmax);
		write_reg(CFG_BPF, bpf);
		write_reg(CFG_NOM, nom);
		write_reg(CFG_PMIN, pmin);
		write_reg(CFG_PMAX, pmax);
		settings_used++;
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (rx_stall_odds != 0 && $urandom_range(0, 99) < rx_stall_odds) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Result checker: every accepted pitch against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			pitches_seen++;
			if (pending_pitch.size() == 0) begin
				$display("%0t: pitch_ppm expected none, got %0d", $time, pitch_ppm);
				mismatches++;
			end else begin
				owed = pending_pitch.pop_front();
				if (pitch_ppm !== owed) begin
					$display("%0t: pitch_ppm expected %0d, got %0d", $time, owed, pitch_ppm);
					mismatches++;
				end
			end
		end
	end

	// Reset defaults: 48 kHz at 256 bits per frame, so 1228800 bits in 100 ms is unity
	task automatic test_priming_and_zero_differences();
		send_snapshot(32'd0, 63'd0);                 // first request only primes
		send_snapshot(32'd1228800, 63'd100_000_000); // unity pitch
		send_snapshot(32'd1228800, 63'd100_000_000); // both differences zero
		send_snapshot(32'd1228800, 63'd200_000_000); // count unchanged
		send_snapshot(32'd2457600, 63'd200_000_000); // time unchanged
		send_snapshot(32'd3686400, 63'd300_000_000);
	endtask

	task automatic test_field_extremes();
		send_snapshot(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF); // huge span, low clamp
		send_snapshot(32'hFFFF_FFFF, 63'd0);                   // time backwards, count still
		send_snapshot(32'hFFFF_FFF0, 63'd1000);                // count backwards: wraps
		send_snapshot(32'h0012_BFF0, 63'd100_001_000);         // count wraps through zero
		send_snapshot(32'h0025_7FF0, 63'd0);                   // time backwards
		send_snapshot(32'h0025_7FEF, 63'd1);                   // full-range count in 1 ns
		send_snapshot(32'd0, 63'h7FFF_FFFF_FFFF_FFFF);
		send_snapshot(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFE);
	endtask

	task automatic test_register_extremes();
		drain_and_idle();
		write_setting(21'd1, 21'd1, 21'd0, 21'h1F_FFFF);
		send_step(32'd1, 64'd1);                 // ratio far above the top of the range
		send_step(32'd1, 64'd1_000_000_000_000); // ratio rounds down to zero
		drain_and_idle();
		write_setting(21'h7FF, 21'h7_FFFF, 21'h1F_FFFF, 21'd2_000_000); // floor above ceiling
		send_step(32'd39_321_600, 64'd100_000_000);
		drain_and_idle();
		write_setting(21'd1024, 21'd384000, 21'd0, 21'd2_000_000);
		send_step(32'd39_321_600, 64'd100_000_000);
		drain_and_idle();
		write_reg(CFG_BPF, 21'd0);               // zero frame length: no pitch
		send_step(32'd1_228_800, 64'd100_000_000);
		drain_and_idle();
		write_setting(21'd256, 21'd0, 21'd750000, 21'd1005000); // zero nominal rate: no pitch
		send_step(32'd1_228_800, 64'd100_000_000);
		drain_and_idle();
		write_reg(CFG_NOM, 21'd48000);
		send_step(32'd1_228_800, 64'd100_000_000);
	endtask

	// Receiver holds off while requests keep coming: one pitch waits at the
	// output, the next stalls in the clamp step and in_ready drops.
	task automatic test_output_backpressure();
		drain_and_idle();
		tx_gap_odds   = 0;
		rx_stall_odds = 0;
		hold_off_req  = 1'b1;
		repeat (6) send_step(32'd1_228_800 + $urandom_range(0, 20000), 64'd100_000_000);
		drain_and_idle();   // sender pauses until the last pitch is back
	endtask

	task automatic pick_register_setting();
		logic [CFG_W-1:0] bpf, nom, pmin, pmax;
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 5))
				0: bpf = 21'd32;
				1: bpf = 21'd64;
				2: bpf = 21'd256;
				3: bpf = 21'd1;
				4: bpf = 21'd1024;
				default: bpf = CFG_W'($urandom_range(1, 1024));
			endcase
			case ($urandom_range(0, 6))
				0: nom = 21'd8000;
				1: nom = 21'd44100;
				2: nom = 21'd48000;
				3: nom = 21'd96000;
				4: nom = 21'd384000;
				5: nom = 21'd1;
				default: nom = CFG_W'($urandom_range(1, 384000));
			endcase
			pmin = CFG_W'($urandom_range(0, 1_000_000));
			pmax = CFG_W'($urandom_range(pmin, 2_000_000));
		end else begin
			// anything the register widths hold, crossed clamps included
			bpf  = CFG_W'($urandom);
			nom  = CFG_W'($urandom);
			pmin = CFG_W'($urandom);
			pmax = CFG_W'($urandom);
		end
		write_setting(bpf, nom, pmin, pmax);
	endtask

	// Mostly plausible snapshot streams near the nominal rate, with noise,
	// repeats, single-field changes and backward time mixed in.
	task automatic test_random_snapshots();
		int           kind;
		logic [63:0]  dt;
		logic [63:0]  noise_t;
		logic [127:0] span;
		logic [31:0]  dc;
		for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
			drain_and_idle();
			pick_register_setting();
			if (chunk >= RANDOM_CHUNKS - 2) begin
				tx_gap_odds   = 0;   // closing stretch runs flat out
				rx_stall_odds = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: tx_gap_odds = 0;
					1: tx_gap_odds = 10;
					2: tx_gap_odds = 25;
					default: tx_gap_odds = 50;
				endcase
				case ($urandom_range(0, 3))
					0: rx_stall_odds = 0;
					1: rx_stall_odds = 2;
					2: rx_stall_odds = 5;
					default: rx_stall_odds = 15;
				endcase
			end
			for (int i = 0; i < CHUNK_ITEMS; i++) begin
				if (chunk < RANDOM_CHUNKS - 2 && $urandom_range(0, 199) == 0)
					drain_and_idle();
				dt   = 64'($urandom_range(1_000_000, 100_000_000));
				span = 128'(r_nom) * 128'(r_bpf) * 128'($urandom_range(600_000, 1_200_000))
				       * 128'(dt) / 128'(64'd1_000_000_000_000_000);
				dc   = span[31:0];
				kind = int'($urandom_range(0, 99));
				if (kind < 80)
					send_step(dc, dt);
				else if (kind < 88) begin
					noise_t = {$urandom, $urandom};
					send_snapshot($urandom, noise_t[TIME_IN_W-1:0]);
				end else if (kind < 92)
					send_step(32'd0, 64'd0);
				else if (kind < 94)
					send_step(dc, 64'd0);
				else if (kind < 96)
					send_step(32'd0, dt);
				else
					send_step(dc, 64'd0 - dt);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_priming_and_zero_differences();
		test_field_extremes();
		test_register_extremes();
		test_output_backpressure();
		test_random_snapshots();

		drain_and_idle();
		$display("%0d snapshot requests, %0d pitches checked, %0d register settings",
			 requests_sent, pitches_seen, settings_used);
		$display("covered priming, zero spans, wrap, backward time, clamps, hold-off");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
